/* rtl/core/npiq_pkg.sv */
`default_nettype none

package npiq_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned EntryW = 9;
  localparam int unsigned DistW = 18;

  localparam logic [CfgIdxW-1:0] CFG_TRANSPARENT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE = 2'd2;

  localparam logic [7:0] TRANSPARENT_RST = 8'hE3;
  localparam logic [8:0] COUNT_RST = 9'd256;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_PIXEL = 1'b1;
  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;
  localparam logic [DistW-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic accept;
    logic issue;
    logic finish;
  } npiq_cmd_t;

  typedef struct packed {
    logic in_pixel;
    logic in_opaque;
    logic scan_done;
    logic pipe_busy;
    logic can_finish;
  } npiq_sts_t;

  function automatic logic [7:0] level_expand(input logic [2:0] lvl);
    logic [7:0] v;
    case (lvl)
      3'd0: v = 8'd0;
      3'd1: v = 8'd36;
      3'd2: v = 8'd73;
      3'd3: v = 8'd109;
      3'd4: v = 8'd146;
      3'd5: v = 8'd182;
      3'd6: v = 8'd219;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // reset palette entry: rrr ggg and a blue level spread from two bits
  function automatic logic [EntryW-1:0] default_entry(input logic [7:0] idx);
    logic [2:0] blue;
    blue = {idx[1:0], idx[1] | idx[0]};
    return {idx[7:5], idx[4:2], blue};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/npiq_ctrl.sv */
`default_nettype none

module npiq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  npiq_pkg::npiq_sts_t     sts_i,
  output npiq_pkg::npiq_cmd_t     cmd_o
);
  import npiq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i & (state_q == ST_IDLE);

  assign cmd_o.accept = accept;
  assign cmd_o.issue = (state_q == ST_SEARCH);
  assign cmd_o.finish = (state_q == ST_FINISH) & sts_i.can_finish;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.in_pixel) begin
          state_d = sts_i.in_opaque ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.scan_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.can_finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/npiq_dp.sv */
`default_nettype none

module npiq_dp #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_i,
  input  wire logic [npiq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [npiq_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    entry_index_i,
  input  wire logic [2:0]                    entry_red_i,
  input  wire logic [2:0]                    entry_green_i,
  input  wire logic [2:0]                    entry_blue_i,
  input  wire logic [7:0]                    pixel_red_i,
  input  wire logic [7:0]                    pixel_green_i,
  input  wire logic [7:0]                    pixel_blue_i,
  input  wire logic [7:0]                    pixel_alpha_i,
  input  npiq_pkg::npiq_cmd_t                cmd_i,
  output npiq_pkg::npiq_sts_t                sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o
);
  import npiq_pkg::*;

  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DepthCnt = 9'(PALETTE_DEPTH);

  // configuration
  logic [7:0] transparent_q;
  logic [8:0] count_q;
  logic       mode_q;

  // palette memory with per-entry written bits
  logic [EntryW-1:0]        mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written_q;

  // item registers
  logic [7:0] pix_r_q, pix_g_q, pix_b_q;
  logic       opaque_q;
  logic [8:0] cnt_q;
  logic [8:0] limit;
  logic       iss;

  // read stage
  logic              rd_vld_q;
  logic [EntryW-1:0] rd_data_q;
  logic              rd_written_q;
  logic [7:0]        rd_idx_q;
  logic [EntryW-1:0] entry;

  // square stage
  logic        sq_vld_q;
  logic        sq_skip_q;
  logic [7:0]  sq_idx_q;
  logic [15:0] sq_r_q, sq_g_q, sq_b_q;
  logic [15:0] sq_r_d, sq_g_d, sq_b_d;
  logic [DistW-1:0] sq_sum;

  logic [DistW-1:0] best_q;
  logic [7:0]       best_idx_q;

  // pair packing and output
  logic       nibble_q;
  logic [7:0] held_q;
  logic [7:0] x;
  logic       needs_out;
  logic       out_valid_q;
  logic [7:0] out_byte_q;

  logic       entry_wr;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  assign limit = (count_q > DepthCnt) ? DepthCnt : count_q;
  assign iss = cmd_i.issue & (cnt_q < limit);
  assign entry_wr = cmd_i.accept & (action_i == ACTION_WRITE) &
                    ({1'b0, entry_index_i} < DepthCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transparent_q <= TRANSPARENT_RST;
      count_q <= COUNT_RST;
      mode_q <= 1'b0;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_TRANSPARENT: transparent_q <= cfg_data_i[7:0];
        CFG_COUNT: count_q <= cfg_data_i;
        CFG_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_wr) begin
      mem[entry_index_i[AddrW-1:0]] <= {entry_red_i, entry_green_i, entry_blue_i};
    end
    if (iss) begin
      rd_data_q <= mem[cnt_q[AddrW-1:0]];
      rd_written_q <= written_q[cnt_q[AddrW-1:0]];
      rd_idx_q <= cnt_q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (entry_wr) begin
      written_q[entry_index_i[AddrW-1:0]] <= 1'b1;
    end
  end

  assign entry = rd_written_q ? rd_data_q : default_entry(rd_idx_q);

  assign sq_r_d = sq_diff(level_expand(entry[8:6]), pix_r_q);
  assign sq_g_d = sq_diff(level_expand(entry[5:3]), pix_g_q);
  assign sq_b_d = sq_diff(level_expand(entry[2:0]), pix_b_q);
  assign sq_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_r_q <= pixel_red_i;
      pix_g_q <= pixel_green_i;
      pix_b_q <= pixel_blue_i;
      opaque_q <= (pixel_alpha_i == OPAQUE_ALPHA);
    end
    if (rd_vld_q) begin
      sq_r_q <= sq_r_d;
      sq_g_q <= sq_g_d;
      sq_b_q <= sq_b_d;
      sq_idx_q <= rd_idx_q;
      sq_skip_q <= (rd_idx_q == transparent_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      best_q <= DIST_MAX;
      best_idx_q <= '0;
    end else begin
      rd_vld_q <= iss;
      sq_vld_q <= rd_vld_q;
      if (cmd_i.accept) begin
        cnt_q <= '0;
        best_q <= DIST_MAX;
        best_idx_q <= '0;
      end else begin
        if (iss) begin
          cnt_q <= cnt_q + 9'd1;
        end
        if (sq_vld_q && !sq_skip_q && (sq_sum < best_q)) begin
          best_q <= sq_sum;
          best_idx_q <= sq_idx_q;
        end
      end
    end
  end

  assign x = opaque_q ? best_idx_q : transparent_q;
  assign needs_out = !mode_q || nibble_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nibble_q <= 1'b0;
      held_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish && needs_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr_i && (cfg_index_i == CFG_MODE)) begin
        nibble_q <= 1'b0;
        held_q <= '0;
      end else if (cmd_i.finish) begin
        if (mode_q) begin
          nibble_q <= !nibble_q;
          if (!nibble_q) begin
            held_q <= {x[3:0], 4'h0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && needs_out) begin
      out_byte_q <= mode_q ? (held_q + x) : x;
    end
  end

  assign sts_o.in_pixel = (action_i == ACTION_PIXEL);
  assign sts_o.in_opaque = (pixel_alpha_i == OPAQUE_ALPHA);
  assign sts_o.scan_done = (cnt_q >= limit);
  assign sts_o.pipe_busy = rd_vld_q | sq_vld_q;
  assign sts_o.can_finish = !(needs_out && out_valid_q && out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;

endmodule

`default_nettype wire

/* rtl/core/nearest_palette_index_quantizer.sv */
`default_nettype none

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | action, entry_*, pixel_*
// out     | output    | out_valid / out_stall | out_byte
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word in flight; an entry write is done when it is accepted, a non-opaque pixel
// goes straight to finish, an opaque pixel searches min(colour_count, PALETTE_DEPTH)
// entries at one palette read per cycle from the single-port palette memory
// reset restores the default rrrgggbb palette through per-entry written bits
// a finished word waits in the output register while in stays open; a full
// output register stalls only the next word that has a result to deliver
module nearest_palette_index_quantizer #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    entry_index_i,
  input  wire logic [2:0]                    entry_red_i,
  input  wire logic [2:0]                    entry_green_i,
  input  wire logic [2:0]                    entry_blue_i,
  input  wire logic [7:0]                    pixel_red_i,
  input  wire logic [7:0]                    pixel_green_i,
  input  wire logic [7:0]                    pixel_blue_i,
  input  wire logic [7:0]                    pixel_alpha_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [npiq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [npiq_pkg::CfgDataW-1:0] cfg_data_i
);
  import npiq_pkg::*;

  npiq_cmd_t cmd;
  npiq_sts_t sts;

  assign cfg_ready_o = 1'b1;

  npiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  npiq_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .pixel_alpha_i (pixel_alpha_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o)
  );

endmodule

`default_nettype wire

/* dv/nearest_palette_index_quantizer_test.sv */
`timescale 1ns / 1ps

module nearest_palette_index_quantizer_test;
  import npiq_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned WORDS_PER_PHASE = 70;
  localparam logic [63:0] LEVEL_BYTES = {
    8'd255, 8'd219, 8'd182, 8'd146, 8'd109, 8'd73, 8'd36, 8'd0
  };

  typedef struct packed {
    logic       action;
    logic [7:0] entry_index;
    logic [2:0] entry_red;
    logic [2:0] entry_green;
    logic [2:0] entry_blue;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
  } word_t;

  typedef struct {
    logic                is_reg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    word_t               w;
    logic                typed;
    logic [7:0]          want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic action_i;
  logic [7:0] entry_index_i;
  logic [2:0] entry_red_i;
  logic [2:0] entry_green_i;
  logic [2:0] entry_blue_i;
  logic [7:0] pixel_red_i;
  logic [7:0] pixel_green_i;
  logic [7:0] pixel_blue_i;
  logic [7:0] pixel_alpha_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [8:0] pal_entry [256];
  logic [7:0] clear_idx;
  logic [8:0] search_count;
  logic pack_mode;
  logic hi_held;
  logic [7:0] held_pair;

  logic [7:0] expected_bytes [$];
  plan_row_t plan [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic calm = 1'b0;

  nearest_palette_index_quantizer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i(action_i),
    .entry_index_i(entry_index_i),
    .entry_red_i(entry_red_i),
    .entry_green_i(entry_green_i),
    .entry_blue_i(entry_blue_i),
    .pixel_red_i(pixel_red_i),
    .pixel_green_i(pixel_green_i),
    .pixel_blue_i(pixel_blue_i),
    .pixel_alpha_i(pixel_alpha_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o(out_byte_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] level_of(input logic [2:0] lvl);
    return LEVEL_BYTES[lvl*8 +: 8];
  endfunction

  function automatic void reset_palette_model();
    logic [7:0] k;
    for (int i = 0; i < 256; i++) begin
      k = i[7:0];
      pal_entry[i] = {k[7:5], k[4:2], k[1:0], k[1] | k[0]};
    end
    clear_idx = TRANSPARENT_RST;
    search_count = COUNT_RST;
    pack_mode = 1'b0;
    hi_held = 1'b0;
    held_pair = 8'd0;
  endfunction

  function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int unsigned best;
    int unsigned sq_sum;
    int unsigned lim;
    int dr;
    int dg;
    int db;
    logic [7:0] pick;
    best = 32'h0100_0000;
    pick = 8'd0;
    lim = (search_count > 256) ? 256 : search_count;
    for (int i = 0; i < lim; i++) begin
      if (i[7:0] != clear_idx) begin
        dr = int'(level_of(pal_entry[i][8:6])) - int'(r);
        dg = int'(level_of(pal_entry[i][5:3])) - int'(g);
        db = int'(level_of(pal_entry[i][2:0])) - int'(b);
        sq_sum = dr * dr + dg * dg + db * db;
        if (sq_sum < best) begin
          best = sq_sum;
          pick = i[7:0];
        end
      end
    end
    return pick;
  endfunction

  function automatic void apply_word(input word_t w, input logic typed,
                                     input logic [7:0] want);
    logic [7:0] idx;
    logic [7:0] res;
    logic have;
    if (w.action == ACTION_WRITE) begin
      pal_entry[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      return;
    end
    if (w.pixel_alpha != OPAQUE_ALPHA) begin
      idx = clear_idx;
    end else begin
      idx = nearest_entry(w.pixel_red, w.pixel_green, w.pixel_blue);
    end
    have = 1'b1;
    res = idx;
    if (pack_mode) begin
      if (!hi_held) begin
        held_pair = idx << 4;
        hi_held = 1'b1;
        have = 1'b0;
      end else begin
        hi_held = 1'b0;
        res = held_pair + idx;
      end
    end
    if (have) expected_bytes = {expected_bytes, (typed ? want : res)};
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CFG_TRANSPARENT: clear_idx = val[7:0];
      CFG_COUNT: search_count = val;
      CFG_MODE: begin
        pack_mode = val[0];
        hi_held = 1'b0;
        held_pair = 8'd0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pick_component();
    if ($urandom_range(99) < 40) return level_of(3'($urandom_range(7)));
    return 8'($urandom_range(255));
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.action = ($urandom_range(99) < 80) ? ACTION_PIXEL : ACTION_WRITE;
    w.entry_index = 8'($urandom_range(255));
    w.entry_red = 3'($urandom_range(7));
    w.entry_green = 3'($urandom_range(7));
    w.entry_blue = 3'($urandom_range(7));
    w.pixel_red = pick_component();
    w.pixel_green = pick_component();
    w.pixel_blue = pick_component();
    w.pixel_alpha = ($urandom_range(99) < 75) ? OPAQUE_ALPHA : 8'($urandom_range(255));
    return w;
  endfunction

  function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic typed, input logic [7:0] want);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.w = random_word();
    row.w.action = ACTION_PIXEL;
    row.w.pixel_red = r;
    row.w.pixel_green = g;
    row.w.pixel_blue = b;
    row.w.pixel_alpha = a;
    row.typed = typed;
    row.want = want;
    plan = {plan, row};
  endfunction

  function automatic void add_entry(input logic [7:0] idx, input logic [2:0] r,
                                    input logic [2:0] g, input logic [2:0] b);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.w = random_word();
    row.w.action = ACTION_WRITE;
    row.w.entry_index = idx;
    row.w.entry_red = r;
    row.w.entry_green = g;
    row.w.entry_blue = b;
    row.typed = 1'b0;
    row.want = 8'd0;
    plan = {plan, row};
  endfunction

  function automatic void add_reg(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan = {plan, row};
  endfunction

  task automatic send_word(input word_t w, input logic typed, input logic [7:0] want);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = w.action;
    entry_index_i = w.entry_index;
    entry_red_i = w.entry_red;
    entry_green_i = w.entry_green;
    entry_blue_i = w.entry_blue;
    pixel_red_i = w.pixel_red;
    pixel_green_i = w.pixel_green;
    pixel_blue_i = w.pixel_blue;
    pixel_alpha_i = w.pixel_alpha;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(w, typed, want);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // drain results, then give any silent word time to finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, actual %0d", out_byte_o);
        mismatches++;
      end else begin
        if (out_byte_o !== expected_bytes[0]) begin
          $error("out_byte: expected %0d, actual %0d", expected_bytes[0], out_byte_o);
          mismatches++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic prev_reg;
    logic [CfgDataW-1:0] trans_val;
    logic [CfgDataW-1:0] count_val;
    logic [CfgDataW-1:0] mode_val;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACTION_WRITE;
    entry_index_i = '0;
    entry_red_i = '0;
    entry_green_i = '0;
    entry_blue_i = '0;
    pixel_red_i = '0;
    pixel_green_i = '0;
    pixel_blue_i = '0;
    pixel_alpha_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    reset_palette_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset palette and registers
    add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, TRANSPARENT_RST);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd254, 1'b1, TRANSPARENT_RST);
    add_pixel(8'd0, 8'd0, 8'd0, OPAQUE_ALPHA, 1'b1, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255, OPAQUE_ALPHA, 1'b1, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0, OPAQUE_ALPHA, 1'b1, 8'd224);
    add_pixel(8'd0, 8'd0, 8'd255, OPAQUE_ALPHA, 1'b1, 8'd3);
    add_pixel(8'd0, 8'd255, 8'd0, OPAQUE_ALPHA, 1'b1, 8'd28);
    // exact colour of the skipped transparent entry
    add_pixel(8'd255, 8'd0, 8'd255, OPAQUE_ALPHA, 1'b0, 8'd0);
    // tie goes to the lower index
    add_entry(8'd255, 3'd0, 3'd0, 3'd0);
    add_pixel(8'd0, 8'd0, 8'd0, OPAQUE_ALPHA, 1'b1, 8'd0);
    add_entry(8'd0, 3'd7, 3'd7, 3'd7);
    add_pixel(8'd255, 8'd255, 8'd255, OPAQUE_ALPHA, 1'b1, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0, OPAQUE_ALPHA, 1'b0, 8'd0);
    add_pixel(8'd128, 8'd200, 8'd17, OPAQUE_ALPHA, 1'b0, 8'd0);
    // empty search
    add_reg(CFG_COUNT, 9'd0);
    add_pixel(8'd90, 8'd10, 8'd250, OPAQUE_ALPHA, 1'b1, 8'd0);
    // only candidate is the transparent entry
    add_reg(CFG_TRANSPARENT, 9'd0);
    add_reg(CFG_COUNT, 9'd1);
    add_pixel(8'd255, 8'd255, 8'd255, OPAQUE_ALPHA, 1'b1, 8'd0);
    add_pixel(8'd1, 8'd2, 8'd3, 8'd100, 1'b1, 8'd0);
    // count above depth
    add_reg(CFG_TRANSPARENT, 9'd255);
    add_reg(CFG_COUNT, 9'd511);
    add_pixel(8'd200, 8'd100, 8'd50, OPAQUE_ALPHA, 1'b0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0, OPAQUE_ALPHA, 1'b0, 8'd0);
    // packed pairs, wide indices wrap
    add_reg(CFG_MODE, 9'd1);
    add_reg(CFG_TRANSPARENT, TRANSPARENT_RST);
    add_pixel(8'd0, 8'd0, 8'd0, 8'd7, 1'b0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0, 8'd7, 1'b1, 8'h13);
    add_pixel(8'd9, 8'd9, 8'd9, 8'd0, 1'b0, 8'd0);
    add_entry(8'd17, 3'd1, 3'd2, 3'd3);
    add_reg(CFG_MODE, 9'd1);
    add_pixel(8'd36, 8'd73, 8'd109, OPAQUE_ALPHA, 1'b0, 8'd0);
    add_pixel(8'd250, 8'd5, 8'd60, OPAQUE_ALPHA, 1'b0, 8'd0);

    prev_reg = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_reg) begin
        if (!prev_reg) settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_word(plan[k].w, plan[k].typed, plan[k].want);
      end
      prev_reg = plan[k].is_reg;
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          trans_val = TRANSPARENT_RST;
          count_val = COUNT_RST;
          mode_val = 9'd0;
        end
        1: begin
          trans_val = 9'd0;
          count_val = 9'd256;
          mode_val = 9'd1;
        end
        2: begin
          trans_val = 9'd255;
          count_val = 9'd1;
          mode_val = 9'd0;
        end
        3: begin
          trans_val = 9'd128;
          count_val = 9'd511;
          mode_val = 9'd1;
        end
        4: begin
          trans_val = 9'd7;
          count_val = 9'd0;
          mode_val = 9'd0;
        end
        default: begin
          trans_val = 9'($urandom_range(255));
          count_val = ($urandom_range(1) != 0) ? 9'($urandom_range(40)) :
                                                 9'($urandom_range(511));
          mode_val = 9'($urandom_range(1));
        end
      endcase
      settle();
      write_reg(CFG_TRANSPARENT, trans_val);
      write_reg(CFG_COUNT, count_val);
      write_reg(CFG_MODE, mode_val);
      calm = (p == 6);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(random_word(), 1'b0, 8'd0);
      end
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
